// ----- hw/rtl/cordic_pkg.sv -----
// Shared types, constants and the arctangent table for the CORDIC sine/cosine unit.
`timescale 1ns / 1ps

package cordic_pkg;

  // Number of micro-rotation stages that are built.
  localparam int MAX_ROTATIONS = 32;

  localparam int ANGLE_W = 32;   // Q4.28 input angle
  localparam int OUT_W   = 32;   // Q2.30 results
  localparam int CNT_W   = 6;    // rotation count register
  localparam int Z_W     = 34;   // residual angle, 30 fraction bits
  localparam int XY_W    = 34;   // vector components, 30 fraction bits

  localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [XY_W-1:0] FRAC_ONE    = 34'sd1073741824;

  localparam logic [CNT_W-1:0] ROTATION_COUNT_RESET = CNT_W'(32);

  localparam int ATAN_HEAD_LEN = 10;
  localparam int ATAN_ZERO_AT  = 30;

  localparam logic signed [Z_W-1:0] ATAN_HEAD [ATAN_HEAD_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149
  };

  // Pipeline word between stages.
  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lane_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cos_out;
    logic signed [OUT_W-1:0] sin_out;
  } result_t;

  // atan(2^-i) scaled by 2^30 and truncated; small angles follow 2^(30-i) - 1.
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] t;
    t = '0;
    if (i < ATAN_HEAD_LEN) begin
      t = ATAN_HEAD[i];
    end else if (i < ATAN_ZERO_AT) begin
      t = (Z_W'(1) << (ATAN_ZERO_AT - i)) - Z_W'(1);
    end
    return t;
  endfunction

endpackage

// ----- hw/rtl/cordic_ifs.sv -----
// Channel interfaces for angle words, result words and configuration words.
`timescale 1ns / 1ps

interface cordic_angle_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [cordic_pkg::ANGLE_W-1:0]     angle_in;
  modport source (output valid, output angle_in, input ready);
  modport sink   (input valid, input angle_in, output ready);
endinterface

interface cordic_result_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [cordic_pkg::OUT_W-1:0]       cos_out;
  logic signed [cordic_pkg::OUT_W-1:0]       sin_out;
  modport source (output valid, output cos_out, output sin_out, input ready);
  modport sink   (input valid, input cos_out, input sin_out, output ready);
endinterface

interface cordic_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [cordic_pkg::CNT_W-1:0]              rotation_count;
  modport source (output valid, output rotation_count, input ready);
  modport sink   (input valid, input rotation_count, output ready);
endinterface

// ----- hw/rtl/cordic_fold.sv -----
// Two-stage range reduction of the input angle into [-pi/2, pi/2].
`timescale 1ns / 1ps

module cordic_fold (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic                                  in_valid,
  input  logic signed [cordic_pkg::ANGLE_W-1:0] angle_in,
  output cordic_pkg::lane_t                     lane_out
);
  import cordic_pkg::*;

  logic                  wrap_valid;
  logic signed [Z_W-1:0] wrap_z;
  logic signed [Z_W-1:0] z_scaled;
  logic signed [Z_W-1:0] wrap_z_next;
  lane_t                 lane_next;

  // First step removes whole turns.
  always_comb begin
    z_scaled = {angle_in, 2'b00};
    wrap_z_next = z_scaled;
    if (z_scaled > PI_Q30) begin
      wrap_z_next = z_scaled - TWO_PI_Q30;
    end else if (z_scaled < -PI_Q30) begin
      wrap_z_next = z_scaled + TWO_PI_Q30;
    end
  end

  // Second step folds by a half turn; the results are negated at the end.
  always_comb begin
    lane_next.valid = wrap_valid;
    lane_next.flip  = 1'b0;
    lane_next.x     = GAIN_Q30;
    lane_next.y     = '0;
    lane_next.z     = wrap_z;
    if (wrap_z > HALF_PI_Q30) begin
      lane_next.z    = wrap_z - PI_Q30;
      lane_next.flip = 1'b1;
    end else if (wrap_z < -HALF_PI_Q30) begin
      lane_next.z    = wrap_z + PI_Q30;
      lane_next.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_valid     <= 1'b0;
      lane_out.valid <= 1'b0;
    end else if (advance) begin
      wrap_valid <= in_valid;
      wrap_z     <= wrap_z_next;
      lane_out   <= lane_next;
    end
  end

endmodule

// ----- hw/rtl/cordic_rotator.sv -----
// Chain of registered CORDIC micro-rotation stages, one per arctangent entry.
`timescale 1ns / 1ps

module cordic_rotator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [cordic_pkg::CNT_W-1:0] rotation_count,
  input  cordic_pkg::lane_t            lane_in,
  output cordic_pkg::lane_t            lane_out
);
  import cordic_pkg::*;

  lane_t stage [1:MAX_ROTATIONS];

  for (genvar k = 0; k < MAX_ROTATIONS; k++) begin : g_rot
    lane_t cur;
    lane_t nxt;
    logic  apply;

    if (k == 0) begin : g_first
      assign cur = lane_in;
    end else begin : g_rest
      assign cur = stage[k];
    end

    // A stage past the programmed count passes its word through untouched.
    always_comb begin
      nxt   = cur;
      apply = CNT_W'(k) < rotation_count;
      if (apply) begin
        if (!cur.z[Z_W-1]) begin
          nxt.x = cur.x - (cur.y >>> k);
          nxt.y = cur.y + (cur.x >>> k);
          nxt.z = cur.z - atan_entry(k);
        end else begin
          nxt.x = cur.x + (cur.y >>> k);
          nxt.y = cur.y - (cur.x >>> k);
          nxt.z = cur.z + atan_entry(k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage[k+1].valid <= 1'b0;
      end else if (advance) begin
        stage[k+1] <= nxt;
      end
    end
  end

  assign lane_out = stage[MAX_ROTATIONS];

endmodule

// ----- hw/rtl/cordic_out_buf.sv -----
// Saturation, sign fold and a two-word output buffer in front of the result port.
`timescale 1ns / 1ps

module cordic_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  cordic_pkg::lane_t     lane_in,
  output logic                  advance,
  output logic                  res_valid,
  input  logic                  res_ready,
  output cordic_pkg::result_t   res
);
  import cordic_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  result_t    word_next;

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [XY_W-1:0] v,
                                                     input logic flip);
    logic signed [XY_W-1:0] c;
    c = v;
    if (v > FRAC_ONE) begin
      c = FRAC_ONE;
    end else if (v < -FRAC_ONE) begin
      c = -FRAC_ONE;
    end
    if (flip) begin
      c = -c;
    end
    return c[OUT_W-1:0];
  endfunction

  always_comb begin
    word_next.cos_out = finish(lane_in.x, lane_in.flip);
    word_next.sin_out = finish(lane_in.y, lane_in.flip);
  end

  assign advance   = count != 2'd2;
  assign push      = advance && lane_in.valid;
  assign res_valid = count != 2'd0;
  assign pop       = res_valid && res_ready;
  assign res       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/cordic_sine_cosine_unit.sv -----
// Top level of the pipelined CORDIC sine/cosine unit.
//
//   channel  role   payload                        width
//   angle    sink   angle_in, Q4.28 radians        32 signed
//   result   source cos_out, sin_out, Q2.30        32 + 32 signed
//   cfg      sink   rotation_count (1..32 used)    6 unsigned
//
// One angle word is taken every cycle while the output buffer has room. A result word
// passes through two fold stages, one stage per micro-rotation and one buffer write.
// The pipeline advances as a whole whenever the two-word output buffer has room, so a
// held result stalls the input only once the buffer is full.
// Synchronous reset empties the pipeline and the buffer and sets rotation_count to 32.
`timescale 1ns / 1ps

module cordic_sine_cosine_unit (
  input  logic              clk,
  input  logic              rst,
  cordic_angle_if.sink      angle,
  cordic_result_if.source   result,
  cordic_cfg_if.sink        cfg
);
  import cordic_pkg::*;

  logic             advance;
  logic [CNT_W-1:0] rotation_count;
  lane_t            folded;
  lane_t            rotated;
  result_t          res;

  // The count must only be written while no angle is in flight (not enforced
  // here), so every stage may compare against the live register. Counts above
  // the built depth enable every stage, which matches clamping to MAX_ROTATIONS.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_count <= ROTATION_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      rotation_count <= cfg.rotation_count;
    end
  end

  // Input acceptance follows the pipeline advance signal, which depends only on
  // the registered fill level of the output buffer.
  assign angle.ready = advance;

  cordic_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (angle.valid),
    .angle_in (angle.angle_in),
    .lane_out (folded)
  );

  cordic_rotator u_rotator (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .rotation_count (rotation_count),
    .lane_in        (folded),
    .lane_out       (rotated)
  );

  // Saturation to [-1, 1] and the half-turn negation happen as the word enters
  // the buffer.
  cordic_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .lane_in   (rotated),
    .advance   (advance),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res       (res)
  );

  assign result.cos_out = res.cos_out;
  assign result.sin_out = res.sin_out;

endmodule
